/* design/mbrot_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time block.
// Used by mbrot_mul, mbrot_core and mandelbrot_escape_time; no dependencies.
package mbrot_pkg;

  localparam int COORD_BITS       = 48;
  localparam int PIXEL_INDEX_BITS = 12;
  localparam int ITER_BITS        = 16;

  localparam int FRAC_BITS = 28;

  // A kept z has |re|, |im| below 2^37 (|z|^2 never above 100000).
  localparam int MAG_W = 37;

  // Shared multiplier: MAG_W x half-width, unsigned.
  localparam int MUL_A_W = MAG_W;
  localparam int MUL_B_W = (MAG_W + 1) / 2;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Exact square / cross product of two magnitudes.
  localparam int P_W = 2 * MAG_W;

  // Point mapping: step split into MAG_W-bit chunks, pixel index on port B.
  localparam int MAP_CHUNKS = (COORD_BITS + MAG_W - 1) / MAG_W;
  localparam int MAP_PAD_W  = MAP_CHUNKS * MAG_W;
  localparam int MAP_W      = MAP_PAD_W + MUL_P_W;
  localparam int IDX_W      = (MAP_CHUNKS > 2) ? $clog2(MAP_CHUNKS) : 1;

  localparam int MAP_OPS = 2 * MAP_CHUNKS;
  localparam int MUL_OPS = 6;
  localparam int CNT_W   = $clog2(((MAP_OPS > MUL_OPS) ? MAP_OPS : MUL_OPS) + 1);

  // Candidate z components before the range check.
  localparam int TERM_W = P_W - FRAC_BITS + 2;
  localparam int SUM_W  = ((COORD_BITS > TERM_W) ? COORD_BITS : TERM_W) + 2;

  // 100000 in the 56-fraction-bit format of |z|^2.
  localparam logic [P_W:0] ESC_LIMIT = (P_W + 1)'(100000) << (2 * FRAC_BITS);

  localparam longint X_START_RST  = -536870912;
  localparam longint X_STEP_RST   = 262144;
  localparam longint Y_START_RST  = -536870912;
  localparam longint Y_STEP_RST   = 262144;
  localparam longint MAX_ITER_RST = 256;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_START  = 3'd0,
    CFG_X_STEP   = 3'd1,
    CFG_Y_START  = 3'd2,
    CFG_Y_STEP   = 3'd3,
    CFG_MAX_ITER = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] x_step;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] y_step;
    logic        [ITER_BITS-1:0]  max_iter;
  } cfg_t;

  typedef enum logic [2:0] {
    MK_MAP_X = 3'd0,
    MK_MAP_Y = 3'd1,
    MK_SQ_RE = 3'd2,
    MK_SQ_IM = 3'd3,
    MK_CROSS = 3'd4
  } mul_kind_t;

  // Travels with each product so the sequencer knows where it goes.
  typedef struct packed {
    logic             valid;
    mul_kind_t        kind;
    logic [IDX_W-1:0] idx;
  } mul_tag_t;

endpackage

/* design/mbrot_mul.sv */
// Shared unsigned multiplier with a registered product and routing tag.
// Depends on mbrot_pkg.
module mbrot_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mbrot_pkg::MUL_A_W-1:0] a,
  input  logic [mbrot_pkg::MUL_B_W-1:0] b,
  input  mbrot_pkg::mul_tag_t           tag_in,
  output logic [mbrot_pkg::MUL_P_W-1:0] prod_r,
  output mbrot_pkg::mul_tag_t           tag_r
);

  logic [mbrot_pkg::MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = mbrot_pkg::MUL_P_W'(a) * mbrot_pkg::MUL_P_W'(b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

/* design/mbrot_core.sv */
// Sequencer and datapath: point mapping, z = z*z + c steps and escape test.
// Depends on mbrot_pkg and mbrot_mul.
module mbrot_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mbrot_pkg::cfg_t                        cfg,
  input  logic                                   start_acc,
  input  logic [mbrot_pkg::PIXEL_INDEX_BITS-1:0] column,
  input  logic [mbrot_pkg::PIXEL_INDEX_BITS-1:0] row,
  output logic                                   busy,
  output logic                                   res_valid,
  output logic [mbrot_pkg::ITER_BITS-1:0]        res_count
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MAP   = 7'b0000010,
    S_ADD   = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_TEST  = 7'b0100000,
    S_UPD   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [mbrot_pkg::CNT_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [mbrot_pkg::ITER_BITS-1:0] n_r, n_nxt;
  logic [mbrot_pkg::PIXEL_INDEX_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic signed [mbrot_pkg::COORD_BITS-1:0] cre_r, cre_nxt, cim_r, cim_nxt;
  logic signed [mbrot_pkg::SUM_W-1:0] dre_r, dre_nxt, t3_r, t3_nxt;
  logic signed [mbrot_pkg::SUM_W-1:0] nre_r, nre_nxt, nim_r, nim_nxt;
  logic [mbrot_pkg::MAG_W-1:0] magre_r, magre_nxt, magim_r, magim_nxt;
  logic neg_r, neg_nxt;
  logic [mbrot_pkg::P_W-1:0] p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic res_valid_r, res_valid_nxt;
  logic [mbrot_pkg::ITER_BITS-1:0] res_count_r, res_count_nxt;

  logic [mbrot_pkg::MUL_A_W-1:0] mul_a;
  logic [mbrot_pkg::MUL_B_W-1:0] mul_b;
  mbrot_pkg::mul_tag_t mul_tag;
  logic [mbrot_pkg::MUL_P_W-1:0] prod;
  mbrot_pkg::mul_tag_t prod_tag;

  logic map_y;
  logic [mbrot_pkg::IDX_W-1:0] map_idx;
  logic [mbrot_pkg::MAP_PAD_W-1:0] step_pad;
  logic [mbrot_pkg::MAG_W-1:0] bsrc;
  logic [2*mbrot_pkg::MUL_B_W-1:0] bsrc_ext;
  logic [mbrot_pkg::MAP_W-1:0] map_wide;
  logic [mbrot_pkg::P_W-1:0] sq_add;
  logic [mbrot_pkg::P_W:0] mag_sum;
  logic signed [mbrot_pkg::P_W:0] sp3, sh3;

  function automatic logic fits(input logic signed [mbrot_pkg::SUM_W-1:0] v);
    logic [mbrot_pkg::SUM_W-mbrot_pkg::MAG_W-1:0] top;
    top = v[mbrot_pkg::SUM_W-1:mbrot_pkg::MAG_W];
    // -2^37 has the right sign bits but still escapes
    return (top == '0) || ((&top) && (v[mbrot_pkg::MAG_W-1:0] != '0));
  endfunction

  function automatic logic [mbrot_pkg::MAG_W-1:0] mag_of(
    input logic signed [mbrot_pkg::SUM_W-1:0] v);
    logic [mbrot_pkg::MAG_W-1:0] m;
    m = v[mbrot_pkg::MAG_W-1:0];
    if (v[mbrot_pkg::SUM_W-1]) begin
      m = ~m + 1'b1;
    end
    return m;
  endfunction

  mbrot_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .a      (mul_a),
    .b      (mul_b),
    .tag_in (mul_tag),
    .prod_r (prod),
    .tag_r  (prod_tag)
  );

  // Operand select for the shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_tag  = '0;
    map_y    = (iss_cnt_r >= mbrot_pkg::CNT_W'(mbrot_pkg::MAP_CHUNKS));
    map_idx  = map_y ?
               mbrot_pkg::IDX_W'(iss_cnt_r - mbrot_pkg::CNT_W'(mbrot_pkg::MAP_CHUNKS)) :
               mbrot_pkg::IDX_W'(iss_cnt_r);
    step_pad = mbrot_pkg::MAP_PAD_W'($unsigned(map_y ? cfg.y_step : cfg.x_step));
    bsrc     = magre_r;
    bsrc_ext = (2 * mbrot_pkg::MUL_B_W)'(bsrc);
    if (state_r == S_MAP && iss_cnt_r < mbrot_pkg::CNT_W'(mbrot_pkg::MAP_OPS)) begin
      mul_a         = mbrot_pkg::MAG_W'(step_pad >> (map_idx * mbrot_pkg::MAG_W));
      mul_b         = mbrot_pkg::MUL_B_W'(map_y ? row_r : col_r);
      mul_tag.valid = 1'b1;
      mul_tag.kind  = map_y ? mbrot_pkg::MK_MAP_Y : mbrot_pkg::MK_MAP_X;
      mul_tag.idx   = map_idx;
    end else if (state_r == S_MUL &&
                 iss_cnt_r < mbrot_pkg::CNT_W'(mbrot_pkg::MUL_OPS)) begin
      case (iss_cnt_r[mbrot_pkg::CNT_W-1:1])
        0: begin
          mul_a        = magre_r;
          bsrc         = magre_r;
          mul_tag.kind = mbrot_pkg::MK_SQ_RE;
        end
        1: begin
          mul_a        = magim_r;
          bsrc         = magim_r;
          mul_tag.kind = mbrot_pkg::MK_SQ_IM;
        end
        default: begin
          mul_a        = magre_r;
          bsrc         = magim_r;
          mul_tag.kind = mbrot_pkg::MK_CROSS;
        end
      endcase
      bsrc_ext      = (2 * mbrot_pkg::MUL_B_W)'(bsrc);
      // low half first, then high half
      mul_b         = iss_cnt_r[0] ?
                      bsrc_ext[2*mbrot_pkg::MUL_B_W-1:mbrot_pkg::MUL_B_W] :
                      bsrc_ext[mbrot_pkg::MUL_B_W-1:0];
      mul_tag.valid = 1'b1;
      mul_tag.idx   = mbrot_pkg::IDX_W'(iss_cnt_r[0]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    iss_cnt_nxt   = iss_cnt_r;
    n_nxt         = n_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cre_nxt       = cre_r;
    cim_nxt       = cim_r;
    dre_nxt       = dre_r;
    t3_nxt        = t3_r;
    nre_nxt       = nre_r;
    nim_nxt       = nim_r;
    magre_nxt     = magre_r;
    magim_nxt     = magim_r;
    neg_nxt       = neg_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    p3_nxt        = p3_r;
    res_valid_nxt = 1'b0;
    res_count_nxt = res_count_r;

    mag_sum = {1'b0, p1_r} + {1'b0, p2_r};
    sp3     = neg_r ? -$signed({1'b0, p3_r}) : $signed({1'b0, p3_r});
    sh3     = sp3 >>> mbrot_pkg::FRAC_BITS;

    case (state_r)
      S_IDLE: begin
        if (start_acc) begin
          col_nxt     = column;
          row_nxt     = row;
          cre_nxt     = cfg.x_start;
          cim_nxt     = cfg.y_start;
          n_nxt       = '0;
          dre_nxt     = '0;
          t3_nxt      = '0;
          iss_cnt_nxt = '0;
          if (cfg.max_iter == '0) begin
            res_valid_nxt = 1'b1;
            res_count_nxt = '0;
          end else begin
            state_nxt = S_MAP;
          end
        end
      end
      S_MAP: begin
        if (iss_cnt_r != mbrot_pkg::CNT_W'(mbrot_pkg::MAP_OPS)) begin
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end else begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        nre_nxt   = dre_r + mbrot_pkg::SUM_W'(cre_r);
        nim_nxt   = t3_r + mbrot_pkg::SUM_W'(cim_r);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!fits(nre_r) || !fits(nim_r)) begin
          res_valid_nxt = 1'b1;
          res_count_nxt = (n_r == '0) ? '0 : n_r - 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          magre_nxt   = mag_of(nre_r);
          magim_nxt   = mag_of(nim_r);
          neg_nxt     = nre_r[mbrot_pkg::SUM_W-1] ^ nim_r[mbrot_pkg::SUM_W-1];
          iss_cnt_nxt = '0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        if (iss_cnt_r != mbrot_pkg::CNT_W'(mbrot_pkg::MUL_OPS)) begin
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (mag_sum > mbrot_pkg::ESC_LIMIT) begin
          res_valid_nxt = 1'b1;
          res_count_nxt = (n_r == '0) ? '0 : n_r - 1'b1;
          state_nxt     = S_IDLE;
        end else if (mbrot_pkg::ITER_BITS'(n_r + 1'b1) == cfg.max_iter) begin
          res_valid_nxt = 1'b1;
          res_count_nxt = n_r;
          state_nxt     = S_IDLE;
        end else begin
          n_nxt     = n_r + 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // floor each scaled product on its own, as the squares are rounded apart
        dre_nxt   = mbrot_pkg::SUM_W'(p1_r >> mbrot_pkg::FRAC_BITS) -
                    mbrot_pkg::SUM_W'(p2_r >> mbrot_pkg::FRAC_BITS);
        t3_nxt    = {sh3[mbrot_pkg::SUM_W-2:0], 1'b0};
        state_nxt = S_ADD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Retire the product leaving the multiplier
    map_wide = mbrot_pkg::MAP_W'(prod) << (prod_tag.idx * mbrot_pkg::MAG_W);
    sq_add   = prod_tag.idx[0] ? (mbrot_pkg::P_W'(prod) << mbrot_pkg::MUL_B_W) :
                                 mbrot_pkg::P_W'(prod);
    if (prod_tag.valid) begin
      case (prod_tag.kind)
        mbrot_pkg::MK_MAP_X: cre_nxt = cre_r + map_wide[mbrot_pkg::COORD_BITS-1:0];
        mbrot_pkg::MK_MAP_Y: cim_nxt = cim_r + map_wide[mbrot_pkg::COORD_BITS-1:0];
        mbrot_pkg::MK_SQ_RE: p1_nxt = prod_tag.idx[0] ? p1_r + sq_add : sq_add;
        mbrot_pkg::MK_SQ_IM: p2_nxt = prod_tag.idx[0] ? p2_r + sq_add : sq_add;
        mbrot_pkg::MK_CROSS: p3_nxt = prod_tag.idx[0] ? p3_r + sq_add : sq_add;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_cnt_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    cre_r       <= cre_nxt;
    cim_r       <= cim_nxt;
    dre_r       <= dre_nxt;
    t3_r        <= t3_nxt;
    nre_r       <= nre_nxt;
    nim_r       <= nim_nxt;
    magre_r     <= magre_nxt;
    magim_r     <= magim_nxt;
    neg_r       <= neg_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    p3_r        <= p3_nxt;
    res_count_r <= res_count_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = res_valid_r;
  assign res_count = res_count_r;

endmodule

/* design/mandelbrot_escape_time.sv */
// Top level of the Mandelbrot escape-time block: configuration registers
// and command handshake. Depends on mbrot_pkg and mbrot_core.
//
//  channel | ports                                | transfer
//  --------+--------------------------------------+---------------------------
//  input   | start, busy, in_column, in_row       | start high while busy low
//  result  | out_valid, out_escape_count          | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_index,     | cfg_valid and cfg_ready
//          | cfg_data                             |
//
// A pixel runs point mapping on the shared multiplier, then iteration steps of
// 6 partial products of the 37x19 multiplier, a drain of it, then test, update,
// add and range check; busy stays high throughout. The word is strobed on out_valid
// in the first cycle with busy low.
// A zero iteration limit returns its word in the cycle after the start.
// Synchronous active-low reset loads the default viewport and limit 256.
module mandelbrot_escape_time (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [mbrot_pkg::PIXEL_INDEX_BITS-1:0] in_column,
  input  logic [mbrot_pkg::PIXEL_INDEX_BITS-1:0] in_row,
  output logic                                   out_valid,
  output logic [mbrot_pkg::ITER_BITS-1:0]        out_escape_count,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mbrot_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mbrot_pkg::COORD_BITS-1:0]       cfg_data
);

  mbrot_pkg::cfg_t cfg_r;
  logic start_acc;

  assign cfg_ready = 1'b1;
  assign start_acc = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_start  <= mbrot_pkg::COORD_BITS'(mbrot_pkg::X_START_RST);
      cfg_r.x_step   <= mbrot_pkg::COORD_BITS'(mbrot_pkg::X_STEP_RST);
      cfg_r.y_start  <= mbrot_pkg::COORD_BITS'(mbrot_pkg::Y_START_RST);
      cfg_r.y_step   <= mbrot_pkg::COORD_BITS'(mbrot_pkg::Y_STEP_RST);
      cfg_r.max_iter <= mbrot_pkg::ITER_BITS'(mbrot_pkg::MAX_ITER_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbrot_pkg::CFG_X_START:  cfg_r.x_start  <= cfg_data;
        mbrot_pkg::CFG_X_STEP:   cfg_r.x_step   <= cfg_data;
        mbrot_pkg::CFG_Y_START:  cfg_r.y_start  <= cfg_data;
        mbrot_pkg::CFG_Y_STEP:   cfg_r.y_step   <= cfg_data;
        mbrot_pkg::CFG_MAX_ITER: cfg_r.max_iter <= cfg_data[mbrot_pkg::ITER_BITS-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  mbrot_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start_acc (start_acc),
    .column    (in_column),
    .row       (in_row),
    .busy      (busy),
    .res_valid (out_valid),
    .res_count (out_escape_count)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for mandelbrot_escape_time: drives pixel words, predicts each
// escape count from its own copy of the viewport registers. Depends on mbrot_pkg.
module tb;
  import mbrot_pkg::*;

  typedef logic signed [129:0] wide_t;

  typedef struct packed {
    logic [PIXEL_INDEX_BITS-1:0] column;
    logic [PIXEL_INDEX_BITS-1:0] row;
  } pixel_t;

  localparam int     WATCHDOG_LIMIT = 4 * 65536 * 12;
  localparam int     TAIL_CYCLES    = 64;
  localparam int     NUM_VIEWS      = 8;
  localparam int     ITEMS_PER_VIEW = 210;
  localparam int     MAX_PRINTED    = 20;
  localparam longint ONE_Q          = longint'(1) << FRAC_BITS;
  localparam longint COORD_MAX      = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN      = -(longint'(1) << (COORD_BITS - 1));
  localparam wide_t  S64_MAX        = (wide_t'(1) <<< 63) - 1;
  localparam wide_t  S64_MIN        = -(wide_t'(1) <<< 63);
  localparam wide_t  ESCAPE_BOUND   = wide_t'(100000) <<< (2 * FRAC_BITS);

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [PIXEL_INDEX_BITS-1:0] in_column = '0;
  logic [PIXEL_INDEX_BITS-1:0] in_row = '0;
  logic                        out_valid;
  logic [ITER_BITS-1:0]        out_escape_count;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [COORD_BITS-1:0]       cfg_data = '0;

  cfg_t                 view;
  pixel_t               pixels_waiting[$];
  logic [ITER_BITS-1:0] counts_due[$];
  logic                 word_taken = 1'b0;
  logic                 gaps_on = 1'b1;
  int                   gap_left = 0;
  int                   stall_cycles = 0;
  int                   mismatches = 0;
  int                   pixels_sent = 0;
  int                   results_seen = 0;
  int                   reg_writes = 0;
  int                   deepest = 0;

  mandelbrot_escape_time dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_column        (in_column),
    .in_row           (in_row),
    .out_valid        (out_valid),
    .out_escape_count (out_escape_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic wide_t saturate64(input wide_t v);
    if (v > S64_MAX) return S64_MAX;
    if (v < S64_MIN) return S64_MIN;
    return v;
  endfunction

  // Map the pixel into the plane and run z = z*z + c until escape or the limit.
  function automatic logic [ITER_BITS-1:0] predict_escape(
      input logic [PIXEL_INDEX_BITS-1:0] col, input logic [PIXEL_INDEX_BITS-1:0] row);
    logic [COORD_BITS-1:0] re_bits, im_bits;
    wide_t c_re, c_im, z_re, z_im, n_re, n_im;
    int unsigned steps;
    bit escaped;
    // mapping wraps modulo 2^COORD_BITS
    re_bits = view.x_start + COORD_BITS'(col) * view.x_step;
    im_bits = view.y_start + COORD_BITS'(row) * view.y_step;
    c_re = $signed(re_bits);
    c_im = $signed(im_bits);
    z_re = '0;
    z_im = '0;
    steps = 0;
    escaped = 1'b0;
    while (!escaped && steps < view.max_iter) begin
      // arithmetic shift of the exact product rounds toward minus infinity
      n_re = saturate64(((z_re * z_re) >>> FRAC_BITS) - ((z_im * z_im) >>> FRAC_BITS) + c_re);
      n_im = saturate64(2 * ((z_re * z_im) >>> FRAC_BITS) + c_im);
      if (n_re * n_re + n_im * n_im > ESCAPE_BOUND) begin
        escaped = 1'b1;
      end else begin
        z_re = n_re;
        z_im = n_im;
        steps++;
      end
    end
    // escape on the very first step clamps to zero
    return (steps == 0) ? '0 : ITER_BITS'(steps - 1);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic queue_pixel(input int col, input int row);
    pixel_t p;
    p.column = PIXEL_INDEX_BITS'(col);
    p.row = PIXEL_INDEX_BITS'(row);
    pixels_waiting.push_back(p);
    pixels_sent++;
  endtask

  // Wait until every queued pixel has been taken and every count has come back.
  task automatic settle();
    while (pixels_waiting.size() != 0 || counts_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_X_START:  view.x_start = data;
      CFG_X_STEP:   view.x_step = data;
      CFG_Y_START:  view.y_start = data;
      CFG_Y_STEP:   view.y_step = data;
      CFG_MAX_ITER: view.max_iter = data[ITER_BITS-1:0];
      default: ;  // spare index: no register behind it
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin : driver
    logic send;
    send = 1'b0;
    if (rst_n) begin
      if (word_taken) void'(pixels_waiting.pop_front());
      if (start && !word_taken) begin
        send = 1'b1;  // hold the word until the block takes it
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        gap_left = $urandom_range(0, 4);
      end else begin
        send = (pixels_waiting.size() != 0);
      end
      start <= send;
      if (send) begin
        in_column <= pixels_waiting[0].column;
        in_row <= pixels_waiting[0].row;
      end else begin
        in_column <= PIXEL_INDEX_BITS'($urandom);
        in_row <= PIXEL_INDEX_BITS'($urandom);
      end
    end
  end

  always @(posedge clk) begin : monitor
    logic [ITER_BITS-1:0] want;
    word_taken = rst_n && start && !busy;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (out_escape_count > deepest) deepest = out_escape_count;
      if (counts_due.size() == 0) begin
        report_mismatch($sformatf("escape count %0d with nothing outstanding",
                                  out_escape_count));
      end else begin
        want = counts_due.pop_front();
        if (out_escape_count !== want)
          report_mismatch($sformatf("escape_count %0d, predicted %0d",
                                    out_escape_count, want));
      end
    end
    if (word_taken) counts_due.push_back(predict_escape(in_column, in_row));
    if (word_taken || (rst_n && out_valid === 1'b1) || (cfg_valid && cfg_ready === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d counts outstanding",
                 stall_cycles, counts_due.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    longint xs, dx, ys, dy;
    int cap, count, col, row, run;
    view.x_start = COORD_BITS'(X_START_RST);
    view.x_step = COORD_BITS'(X_STEP_RST);
    view.y_start = COORD_BITS'(Y_START_RST);
    view.y_step = COORD_BITS'(Y_STEP_RST);
    view.max_iter = ITER_BITS'(MAX_ITER_RST);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset viewport: corners, the origin inside the set, a point on the real axis
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    queue_pixel(2048, 2048);
    queue_pixel(1536, 2048);
    settle();

    // far out to the right of the set: escape on the first step
    write_reg(CFG_X_START, COORD_BITS'(400 * ONE_Q));
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(100, 2000);
    settle();

    // extreme registers, mapping wraps around
    write_reg(CFG_X_START, COORD_BITS'(COORD_MAX));
    write_reg(CFG_X_STEP, COORD_BITS'(COORD_MAX));
    write_reg(CFG_Y_START, COORD_BITS'(COORD_MIN));
    write_reg(CFG_Y_STEP, COORD_BITS'(COORD_MIN));
    write_reg(CFG_MAX_ITER, COORD_BITS'(16));
    queue_pixel(0, 0);
    queue_pixel(1, 1);
    queue_pixel(4095, 4095);
    queue_pixel(2, 3);
    settle();

    // spare indexes must leave every register alone
    for (int spare = CFG_MAX_ITER + 1; spare < (1 << CFG_IDX_W); spare++)
      write_reg(CFG_IDX_W'(spare), COORD_BITS'({$urandom, $urandom}));

    // zero limit, with junk above the limit field
    write_reg(CFG_X_START, COORD_BITS'(X_START_RST));
    write_reg(CFG_X_STEP, COORD_BITS'(X_STEP_RST));
    write_reg(CFG_Y_START, COORD_BITS'(Y_START_RST));
    write_reg(CFG_Y_STEP, COORD_BITS'(Y_STEP_RST));
    write_reg(CFG_MAX_ITER, {32'hFFFF_FFFF, 16'h0000});
    queue_pixel(2048, 2048);
    queue_pixel(0, 0);
    settle();
    write_reg(CFG_MAX_ITER, {32'hA5A5_5A5A, 16'h0001});
    queue_pixel(2048, 2048);
    queue_pixel(4095, 4095);
    settle();

    // full limit: the origin runs every step, the rest escape fast
    write_reg(CFG_MAX_ITER, COORD_BITS'(16'hFFFF));
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 2048);
    queue_pixel(2048, 2048);
    settle();

    for (int v = 0; v < NUM_VIEWS; v++) begin
      gaps_on = (v != NUM_VIEWS - 1) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        xs = {$urandom, $urandom};
        dx = {$urandom, $urandom};
        ys = {$urandom, $urandom};
        dy = {$urandom, $urandom};
        cap = $urandom_range(1, 48);
      end else begin
        // window over the set so that counts spread from 0 up to the limit
        xs = -(5 * ONE_Q / 2) + longint'($urandom_range(0, ONE_Q));
        dx = $urandom_range(ONE_Q >> 14, ONE_Q >> 10);
        ys = -(3 * ONE_Q / 2) + longint'($urandom_range(0, ONE_Q));
        dy = $urandom_range(ONE_Q >> 14, ONE_Q >> 10);
        if ($urandom_range(0, 3) == 0) begin
          xs = xs + 4095 * dx;
          dx = -dx;
        end
        if ($urandom_range(0, 3) == 0) begin
          ys = ys + 4095 * dy;
          dy = -dy;
        end
        cap = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 160) : $urandom_range(1, 48);
      end
      write_reg(CFG_X_START, COORD_BITS'(xs));
      write_reg(CFG_X_STEP, COORD_BITS'(dx));
      write_reg(CFG_Y_START, COORD_BITS'(ys));
      write_reg(CFG_Y_STEP, COORD_BITS'(dy));
      write_reg(CFG_MAX_ITER, COORD_BITS'({$urandom, ITER_BITS'(cap)}));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_MAX_ITER + 1, (1 << CFG_IDX_W) - 1)),
                  COORD_BITS'({$urandom, $urandom}));
      count = 0;
      while (count < ITEMS_PER_VIEW) begin
        col = $urandom_range(0, 4095);
        row = $urandom_range(0, 4095);
        // a short scan line now and then, like a renderer walking a row
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : 1;
        for (int k = 0; k < run; k++) queue_pixel(col + k, row);
        count += run;
      end
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (counts_due.size() != 0)
      report_mismatch($sformatf("%0d escape counts never arrived", counts_due.size()));
    $display("Ran %0d pixels through %0d register writes: reset view, first-step escape,",
             pixels_sent, reg_writes);
    $display("wrapped extremes, zero and full limits; %0d counts checked, deepest %0d",
             results_seen, deepest);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
